// ===== hdl/tun_pkg.sv =====
// Package for the triangle unit normal block: defaults and stage control type.
`default_nettype none
package tun_pkg;
  localparam int CoordWidthDef = 16;
  localparam int NormFracDef   = 14;
  localparam int Lanes         = 3;

  typedef struct packed {
    logic             vld;
    logic [Lanes-1:0] neg;
    logic             degen;
  } tun_ctl_t;
endpackage
`default_nettype wire

// ===== hdl/tun_front.sv =====
// Front pipeline: edges, cross product, magnitudes, squared length and targets.
`default_nettype none
module tun_front #(
  parameter int CW = 16,
  parameter int F  = 14,
  parameter int SW = 70,
  parameter int CPW = 100
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_vld,
  input  wire logic [CW-1:0]        a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
  output logic [CPW-1:0]            s_o,
  output logic [2:0][CPW-1:0]       tgt_o,
  output tun_pkg::tun_ctl_t         ctl_o
);
  import tun_pkg::*;
  localparam int EW  = CW + 1;
  localparam int PW  = 2 * EW;
  localparam int NW  = PW + 1;
  localparam int MW  = PW;
  localparam int SQW = 2 * MW;

  logic [3:0] vld_r;
  logic signed [EW-1:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  logic signed [PW-1:0] pr_r [6];
  logic signed [NW-1:0] n_r [3];
  logic [MW-1:0]        m_nxt [3];
  logic [SQW-1:0]       sq_r [3];
  logic [2:0]           neg3_r;
  logic [SW-1:0]        s_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      ctl_o.vld <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[2:0], in_vld};
      ctl_o.vld   <= vld_r[3];
      ctl_o.neg   <= neg3_r;
      ctl_o.degen <= (s_nxt == '0);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m_nxt[k] = n_r[k][NW-1] ? MW'(NW'(0) - n_r[k]) : MW'(n_r[k]);
    end
    s_nxt = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1x_r <= $signed({b_x[CW-1], b_x}) - $signed({a_x[CW-1], a_x});
      e1y_r <= $signed({b_y[CW-1], b_y}) - $signed({a_y[CW-1], a_y});
      e1z_r <= $signed({b_z[CW-1], b_z}) - $signed({a_z[CW-1], a_z});
      e2x_r <= $signed({c_x[CW-1], c_x}) - $signed({a_x[CW-1], a_x});
      e2y_r <= $signed({c_y[CW-1], c_y}) - $signed({a_y[CW-1], a_y});
      e2z_r <= $signed({c_z[CW-1], c_z}) - $signed({a_z[CW-1], a_z});
      pr_r[0] <= e1y_r * e2z_r;
      pr_r[1] <= e1z_r * e2y_r;
      pr_r[2] <= e1z_r * e2x_r;
      pr_r[3] <= e1x_r * e2z_r;
      pr_r[4] <= e1x_r * e2y_r;
      pr_r[5] <= e1y_r * e2x_r;
      for (int k = 0; k < 3; k++) begin
        n_r[k] <= $signed({pr_r[2*k][PW-1], pr_r[2*k]})
                - $signed({pr_r[2*k+1][PW-1], pr_r[2*k+1]});
        sq_r[k] <= m_nxt[k] * m_nxt[k];
        neg3_r[k] <= n_r[k][NW-1];
        tgt_o[k] <= CPW'({sq_r[k], {(2*F){1'b0}}});
      end
      s_o         <= CPW'(s_nxt);
    end
  end
endmodule
`default_nettype wire

// ===== hdl/tun_cell.sv =====
// One quotient bit cell: trial of q + 2^BIT against each lane's target.
`default_nettype none
module tun_cell #(
  parameter int F   = 14,
  parameter int BIT = 14,
  parameter int CPW = 100
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire tun_pkg::tun_ctl_t    ctl_i,
  input  wire logic [CPW-1:0]       s_i,
  input  wire logic [2:0][CPW-1:0]  tgt_i,
  input  wire logic [2:0][CPW-1:0]  p_i,
  input  wire logic [2:0][CPW-1:0]  qs_i,
  input  wire logic [2:0][F:0]      q_i,
  output tun_pkg::tun_ctl_t         ctl_o,
  output logic [CPW-1:0]            s_o,
  output logic [2:0][CPW-1:0]       tgt_o,
  output logic [2:0][CPW-1:0]       p_o,
  output logic [2:0][CPW-1:0]       qs_o,
  output logic [2:0][F:0]           q_o
);
  import tun_pkg::*;
  logic [2:0][CPW-1:0] cand, p_nxt, qs_nxt;
  logic [2:0][F:0]     q_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cand[k] = p_i[k] + (qs_i[k] << (BIT + 1)) + (s_i << (2 * BIT));
      if (cand[k] <= tgt_i[k]) begin
        p_nxt[k]  = cand[k];
        qs_nxt[k] = qs_i[k] + (s_i << BIT);
        q_nxt[k]  = q_i[k] | ((F+1)'(1) << BIT);
      end else begin
        p_nxt[k]  = p_i[k];
        qs_nxt[k] = qs_i[k];
        q_nxt[k]  = q_i[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o.vld <= 1'b0;
    end else if (en) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_o   <= s_i;
      tgt_o <= tgt_i;
      p_o   <= p_nxt;
      qs_o  <= qs_nxt;
      q_o   <= q_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/triangle_unit_normal.sv =====
// Top level: unit face normal of a triangle, front pipeline plus quotient cell chain.
//
//  channel | handshake           | payload
//  in      | in_valid/in_ready   | in_a_x..in_c_z, signed Q8.8
//  out     | out_valid/out_ready | out_normal_x/y/z signed Q1.14, out_degenerate
//
// One triangle per cycle while the output is not stalled; the path runs through the
// front stages, one cell per quotient bit and the output register.
// Synchronous active-low reset clears all valid bits.
// A stalled output transfer freezes the whole pipeline; in_ready follows it.
`default_nettype none
module triangle_unit_normal #(
  parameter int COORD_WIDTH      = tun_pkg::CoordWidthDef,
  parameter int NORMAL_FRAC_BITS = tun_pkg::NormFracDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [COORD_WIDTH-1:0]        in_a_x, in_a_y, in_a_z,
  input  wire logic [COORD_WIDTH-1:0]        in_b_x, in_b_y, in_b_z,
  input  wire logic [COORD_WIDTH-1:0]        in_c_x, in_c_y, in_c_z,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_normal_x,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_normal_y,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_normal_z,
  output logic                               out_degenerate
);
  import tun_pkg::*;
  localparam int F   = NORMAL_FRAC_BITS;
  localparam int OW  = F + 2;
  localparam int MW  = 2 * (COORD_WIDTH + 1);
  localparam int SW  = 2 * MW + 2;
  localparam int CPW = SW + 2 * F + 2;
  localparam int NC  = F + 1;

  logic en;
  tun_ctl_t            ctl_c [NC+1];
  logic [CPW-1:0]      s_c   [NC+1];
  logic [2:0][CPW-1:0] tgt_c [NC+1];
  logic [2:0][CPW-1:0] p_c   [NC+1];
  logic [2:0][CPW-1:0] qs_c  [NC+1];
  logic [2:0][F:0]     q_c   [NC+1];
  logic [2:0][OW-1:0]  nrm_nxt;
  logic [F:0]          qm;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  tun_front #(.CW(COORD_WIDTH), .F(F), .SW(SW), .CPW(CPW)) u_front (
    .clk, .rst_n, .en, .in_vld(in_valid && in_ready),
    .a_x(in_a_x), .a_y(in_a_y), .a_z(in_a_z),
    .b_x(in_b_x), .b_y(in_b_y), .b_z(in_b_z),
    .c_x(in_c_x), .c_y(in_c_y), .c_z(in_c_z),
    .s_o(s_c[0]), .tgt_o(tgt_c[0]), .ctl_o(ctl_c[0])
  );

  assign p_c[0]  = '0;
  assign qs_c[0] = '0;
  assign q_c[0]  = '0;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    tun_cell #(.F(F), .BIT(F - i), .CPW(CPW)) u_cell (
      .clk, .rst_n, .en,
      .ctl_i(ctl_c[i]), .s_i(s_c[i]), .tgt_i(tgt_c[i]),
      .p_i(p_c[i]), .qs_i(qs_c[i]), .q_i(q_c[i]),
      .ctl_o(ctl_c[i+1]), .s_o(s_c[i+1]), .tgt_o(tgt_c[i+1]),
      .p_o(p_c[i+1]), .qs_o(qs_c[i+1]), .q_o(q_c[i+1])
    );
  end

  always_comb begin
    qm = '0;
    for (int k = 0; k < 3; k++) begin
      qm = (q_c[NC][k] > ((F+1)'(1) << F)) ? ((F+1)'(1) << F) : q_c[NC][k];
      if (ctl_c[NC].degen) begin
        nrm_nxt[k] = '0;
      end else if (ctl_c[NC].neg[k]) begin
        nrm_nxt[k] = OW'(0) - {1'b0, qm};
      end else begin
        nrm_nxt[k] = {1'b0, qm};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl_c[NC].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_normal_x   <= nrm_nxt[0];
      out_normal_y   <= nrm_nxt[1];
      out_normal_z   <= nrm_nxt[2];
      out_degenerate <= ctl_c[NC].degen;
    end
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0)
    else $error("degenerate result with nonzero normal");

  a_nondegen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |->
      out_normal_x != '0 || out_normal_y != '0 || out_normal_z != '0)
    else $error("zero normal without degenerate flag");

  a_mag_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_normal_x <= $signed(OW'(1) << F) && out_normal_x >= -$signed(OW'(1) << F))
    else $error("normal_x out of range");
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for triangle_unit_normal: queued random/directed triangles, predicted normals.
`default_nettype none
module testbench;
  localparam int CW = tun_pkg::CoordWidthDef;
  localparam int FB = tun_pkg::NormFracDef;
  localparam int STALL_LIMIT = 400;

  typedef struct {
    logic [CW-1:0] v[9];
  } tri_t;

  typedef struct {
    logic signed [FB+1:0] nx, ny, nz;
    logic                 degen;
  } normal_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CW-1:0] in_a_x = '0, in_a_y = '0, in_a_z = '0;
  logic [CW-1:0] in_b_x = '0, in_b_y = '0, in_b_z = '0;
  logic [CW-1:0] in_c_x = '0, in_c_y = '0, in_c_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [FB+1:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_degenerate;

  triangle_unit_normal dut (.*);

  tri_t    tri_q[$];
  normal_t normal_q[$];
  int      errors = 0;
  int      in_gap = 0, out_gap = 0, stall_cnt = 0;
  logic    in_took = 1'b0;
  logic    calm = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic signed [FB+1:0] unit_component(logic signed [35:0] c,
                                                          logic [127:0] s);
    logic [127:0] mag, target, t, p;
    logic [127:0] q;
    mag = c < 0 ? 128'(-c) : 128'(c);
    target = (mag * mag) << (2 * FB);
    q = '0;
    for (int b = FB; b >= 0; b--) begin
      t = q | (128'(1) << b);
      p = (t * t) * s;
      if (p <= target) q = t;
    end
    if (q > (128'(1) << FB)) q = 128'(1) << FB;
    unit_component = c < 0 ? -(FB+2)'(q) : (FB+2)'(q);
  endfunction

  function automatic normal_t face_normal(tri_t t);
    logic signed [16:0] e1x, e1y, e1z, e2x, e2y, e2z;
    logic signed [35:0] nx, ny, nz;
    logic signed [127:0] wx, wy, wz;
    logic [127:0] s;
    normal_t r;
    e1x = $signed(t.v[3]) - $signed(t.v[0]);
    e1y = $signed(t.v[4]) - $signed(t.v[1]);
    e1z = $signed(t.v[5]) - $signed(t.v[2]);
    e2x = $signed(t.v[6]) - $signed(t.v[0]);
    e2y = $signed(t.v[7]) - $signed(t.v[1]);
    e2z = $signed(t.v[8]) - $signed(t.v[2]);
    nx = e1y * e2z - e1z * e2y;
    ny = e1z * e2x - e1x * e2z;
    nz = e1x * e2y - e1y * e2x;
    wx = nx;
    wy = ny;
    wz = nz;
    s = wx * wx + wy * wy + wz * wz;
    if (s == 0) begin
      r.nx = '0; r.ny = '0; r.nz = '0; r.degen = 1'b1;
    end else begin
      r.nx = unit_component(nx, s);
      r.ny = unit_component(ny, s);
      r.nz = unit_component(nz, s);
      r.degen = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] rand_coord(int mode);
    case (mode)
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(0, 64)) - 32);
      2: return $urandom_range(0, 1) ? 16'h7fff - CW'($urandom_range(0, 3))
                                      : 16'h8000 + CW'($urandom_range(0, 3));
      default: return CW'($signed($urandom_range(0, 2048)) - 1024);
    endcase
  endfunction

  task automatic add_tri(input logic [CW-1:0] a0, a1, a2, b0, b1, b2, c0, c1, c2);
    tri_t t;
    t.v = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
    tri_q.push_back(t);
  endtask

  initial begin
    tri_t t;
    int mode;
    add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_tri(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
            16'h7fff, 16'h7fff);
    add_tri(0, 0, 0, 256, 0, 0, 0, 256, 0);
    add_tri(0, 0, 0, 0, 256, 0, 256, 0, 0);
    add_tri(0, 0, 0, 0, 256, 0, 0, 0, 256);
    add_tri(0, 0, 0, 0, 0, 256, 0, 256, 0);
    add_tri(0, 0, 0, 0, 0, 256, 256, 0, 0);
    add_tri(0, 0, 0, 256, 0, 0, 0, 0, 256);
    add_tri(0, 0, 0, 1, 1, 1, 2, 2, 2);
    add_tri(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
            16'h8000, 16'h7fff, 16'h8000);
    add_tri(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
            16'h8000, 16'h7fff, 16'h7fff);
    add_tri(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
            16'h7fff, 16'h7fff, 16'h8000);
    add_tri(16'hffff, 16'hffff, 16'hffff, 0, 0, 0, 1, 0, 0);
    add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
    add_tri(0, 0, 0, 16'h7fff, 0, 0, 16'h8000, 1, 0);
    add_tri(5, 5, 5, 5, 5, 5, 100, 200, 300);
    add_tri(100, 100, 100, 200, 200, 200, 16'h7fff, 16'h8000, 3);
    add_tri(0, 0, 0, 1, 1, 0, 16'hffff, 1, 16'hffff);
    for (int i = 0; i < 1550; i++) begin
      mode = $urandom_range(0, 9);
      if (mode == 9) begin
        // collinear triangle
        t.v[0] = rand_coord(3); t.v[1] = rand_coord(3); t.v[2] = rand_coord(3);
        for (int k = 0; k < 3; k++) begin
          t.v[3+k] = t.v[k] + CW'(i % 7) * CW'(k + 1);
          t.v[6+k] = t.v[k] + CW'(2 * (i % 7)) * CW'(k + 1);
        end
      end else begin
        for (int k = 0; k < 9; k++) t.v[k] = rand_coord(mode % 4);
      end
      tri_q.push_back(t);
    end
  end

  // stimulus side
  always @(negedge clk) begin
    if (rst_n) begin
      calm <= tri_q.size() < 250;
      if (!in_valid || in_took) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (tri_q.size() > 0) begin
          tri_t t;
          t = tri_q.pop_front();
          {in_a_x, in_a_y, in_a_z} <= {t.v[0], t.v[1], t.v[2]};
          {in_b_x, in_b_y, in_b_z} <= {t.v[3], t.v[4], t.v[5]};
          {in_c_x, in_c_y, in_c_z} <= {t.v[6], t.v[7], t.v[8]};
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) out_gap <= $urandom_range(1, 3);
      end
    end
  end

  // transfer monitor and checks
  always @(posedge clk) begin
    if (rst_n) begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        tri_t t;
        t.v = '{in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z, in_c_x, in_c_y, in_c_z};
        normal_q.push_back(face_normal(t));
      end
      if (out_valid && out_ready) begin
        if (normal_q.size() == 0) begin
          $error("result transfer with no expected normal");
          errors++;
        end else begin
          normal_t e;
          e = normal_q.pop_front();
          if (out_normal_x !== e.nx) begin
            $error("normal_x exp %0d got %0d", e.nx, out_normal_x); errors++;
          end
          if (out_normal_y !== e.ny) begin
            $error("normal_y exp %0d got %0d", e.ny, out_normal_y); errors++;
          end
          if (out_normal_z !== e.nz) begin
            $error("normal_z exp %0d got %0d", e.nz, out_normal_z); errors++;
          end
          if (out_degenerate !== e.degen) begin
            $error("degenerate exp %0b got %0b", e.degen, out_degenerate); errors++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (tri_q.size() == 0 && !in_valid && normal_q.size() == 0);
    repeat (5 + FB + 2 + 10) @(posedge clk);
    if (errors == 0 && normal_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
hdl/tun_pkg.sv
hdl/tun_front.sv
hdl/tun_cell.sv
hdl/triangle_unit_normal.sv
tb/sv/testbench.sv
